>>> design/oggd_pkg.sv
// Shared constants, codes and types for the occupancy grid disc dilation block.
package oggd_pkg;

    // Default build-time dimensions
    localparam int DEF_GRID_WIDTH  = 64;
    localparam int DEF_GRID_HEIGHT = 64;
    localparam int DEF_MAX_RADIUS  = 15;

    // Word field widths
    localparam int KIND_W  = 2;
    localparam int COORD_W = 6;
    localparam int OCC_W   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int RADIUS_W   = 4;
    localparam int THR_W      = 8;
    localparam int DIM_W      = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd3;

    localparam logic [RADIUS_W-1:0] RADIUS_RST    = 4'd3;
    localparam logic [THR_W-1:0]    THRESHOLD_RST = 8'd124;
    localparam logic [DIM_W-1:0]    WIDTH_RST     = 7'd64;
    localparam logic [DIM_W-1:0]    HEIGHT_RST    = 7'd64;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [OCC_W-1:0] OCC_FULL = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELIVER,
        ST_COPY,
        ST_SCAN,
        ST_CHECK,
        ST_DISC
    } oggd_state_t;

endpackage

>>> design/oggd_if.sv
// Valid/ready channel interfaces for command and response words.
interface oggd_cmd_if import oggd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [OCC_W-1:0]   occupancy;

    modport source (output valid, kind, cell_x, cell_y, occupancy, input ready);
    modport sink   (input valid, kind, cell_x, cell_y, occupancy, output ready);
endinterface

interface oggd_rsp_if import oggd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OCC_W-1:0] cell_value;
    logic             run_done;

    modport source (output valid, cell_value, run_done, input ready);
    modport sink   (input valid, cell_value, run_done, output ready);
endinterface

>>> design/occupancy_grid_disc_dilation.sv
// Top level of the occupancy grid obstacle inflation block.
//
// Holds a GRID_WIDTH x GRID_HEIGHT grid of 8-bit occupancy values in a RAM,
// cell (x,y) at y*GRID_WIDTH + x. A write word stores one cell and the
// block is ready again at once, so writes stream back to back. A read word
// goes through the RAM read, then the response register, which waits while
// an earlier response is unclaimed, and returns the cell, or 0 outside the
// area in use. A run word copies the whole grid into a snapshot RAM (one
// RAM read per cycle), then scans the area in use cell by cell (snapshot
// read, threshold compare), and for every cell above the threshold walks the
// (2r+1)^2 square around it at one point per cycle through a single disc
// test unit, writing 255 to in-disc, in-area points. A run waits for any
// earlier response word that is still unclaimed and ends with one response
// word with run_done set and cell_value 0. The command channel is not ready
// while a read or run is in progress; a pending response may sit in the
// output register while the next command is taken. Configuration writes are
// taken at any time but must only be issued while the block is idle.
module occupancy_grid_disc_dilation import oggd_pkg::*; #(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int MAX_RADIUS  = DEF_MAX_RADIUS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    oggd_cmd_if.sink              cmd,
    oggd_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int XW         = $clog2(GRID_WIDTH);
    localparam int YW         = $clog2(GRID_HEIGHT);
    localparam int EW_W       = $clog2(GRID_WIDTH + 1);
    localparam int EH_W       = $clog2(GRID_HEIGHT + 1);
    localparam int R_W        = $clog2(MAX_RADIUS + 1);
    localparam int NX_W       = $clog2(GRID_WIDTH + MAX_RADIUS + 1) + 1;
    localparam int NY_W       = $clog2(GRID_HEIGHT + MAX_RADIUS + 1) + 1;
    localparam int NB_W       = $clog2(CELL_COUNT + (MAX_RADIUS + 1) * GRID_WIDTH) + 1;

    // Configuration registers
    logic [RADIUS_W-1:0] radius_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    // Sequencer state
    oggd_state_t              state_reg, state_next;
    logic [XW-1:0]            x_reg, x_next;
    logic [YW-1:0]            y_reg, y_next;
    logic [CELL_AW-1:0]       base_reg, base_next;      // y*GRID_WIDTH of scan row
    logic signed [R_W:0]      dx_reg, dx_next;
    logic signed [R_W:0]      dy_reg, dy_next;
    logic signed [NB_W-1:0]   nb_base_reg, nb_base_next; // (y+dy)*GRID_WIDTH
    logic [CELL_AW-1:0]       cp_cnt_reg, cp_cnt_next;
    logic                     cpw_valid_reg;
    logic [CELL_AW-1:0]       cpw_addr_reg;
    logic                     pend_run_reg, pend_run_next;
    logic                     pend_inside_reg, pend_inside_next;

    // Response register
    logic             out_valid_reg, out_valid_next;
    logic [OCC_W-1:0] out_value_reg, out_value_next;
    logic             out_done_reg, out_done_next;

    // RAM hookup
    logic               g_we, g_re;
    logic [CELL_AW-1:0] g_waddr, g_raddr;
    logic [OCC_W-1:0]   g_wdata, g_rdata;
    logic               s_re;
    logic [CELL_AW-1:0] s_raddr;
    logic [OCC_W-1:0]   s_rdata;

    // Derived values
    logic [EW_W-1:0]        eff_w;
    logic [EH_W-1:0]        eff_h;
    logic [R_W-1:0]         r_eff;
    logic signed [R_W:0]    r_pos;
    logic signed [R_W:0]    r_neg;
    logic [NB_W-2:0]        r_rows;
    logic                   area_empty;
    logic                   cmd_fire;
    logic                   cmd_inside;
    logic [CELL_AW-1:0]     cmd_addr;
    logic                   last_x, last_y;
    logic signed [NX_W-1:0] nx, ew_s;
    logic signed [NY_W-1:0] ny, eh_s;
    logic                   nx_ok, ny_ok, in_disc, pt_ok;
    logic signed [NB_W-1:0] nb_addr;
    logic                   advance;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            thr_reg    <= THRESHOLD_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS:    radius_reg <= cfg_data[RADIUS_W-1:0];
                CFG_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                CFG_WIDTH:     width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    height_reg <= cfg_data[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // Saturate the area and the radius to what the build supports
    assign eff_w = (32'(width_reg) > GRID_WIDTH) ? EW_W'(GRID_WIDTH) : EW_W'(width_reg);
    assign eff_h = (32'(height_reg) > GRID_HEIGHT) ? EH_W'(GRID_HEIGHT) : EH_W'(height_reg);
    assign r_eff = (32'(radius_reg) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_reg);
    assign r_pos = $signed({1'b0, r_eff});
    assign r_neg = -r_pos;
    assign r_rows = (NB_W-1)'(32'(r_eff) * GRID_WIDTH);
    assign area_empty = (eff_w == '0) || (eff_h == '0);

    assign cmd_fire   = cmd.valid && cmd.ready;
    assign cmd_inside = (32'(cmd.cell_x) < 32'(eff_w)) && (32'(cmd.cell_y) < 32'(eff_h));
    assign cmd_addr   = CELL_AW'(32'(cmd.cell_y) * GRID_WIDTH + 32'(cmd.cell_x));

    assign last_x = (32'(x_reg) + 32'd1 == 32'(eff_w));
    assign last_y = (32'(y_reg) + 32'd1 == 32'(eff_h));

    // Neighbor position and bounds for the disc walk
    assign nx    = NX_W'($signed({1'b0, x_reg})) + NX_W'(dx_reg);
    assign ny    = NY_W'($signed({1'b0, y_reg})) + NY_W'(dy_reg);
    assign ew_s  = NX_W'($signed({1'b0, eff_w}));
    assign eh_s  = NY_W'($signed({1'b0, eff_h}));
    assign nx_ok = !nx[NX_W-1] && (nx < ew_s);
    assign ny_ok = !ny[NY_W-1] && (ny < eh_s);
    assign nb_addr = nb_base_reg + NB_W'(nx);
    assign pt_ok = in_disc && nx_ok && ny_ok;

    oggd_disc_unit #(
        .R_W (R_W)
    ) u_disc (
        .dx      (dx_reg),
        .dy      (dy_reg),
        .r       (r_eff),
        .in_disc (in_disc)
    );

    oggd_ram #(
        .DEPTH (CELL_COUNT),
        .WIDTH (OCC_W)
    ) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    // Snapshot is written in the cycle after the grid read during the copy
    oggd_ram #(
        .DEPTH (CELL_COUNT),
        .WIDTH (OCC_W)
    ) u_snap (
        .clk   (clk),
        .we    (cpw_valid_reg),
        .waddr (cpw_addr_reg),
        .wdata (g_rdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign s_raddr = base_reg + CELL_AW'(x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cpw_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cpw_valid_reg <= (state_reg == ST_COPY);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        y_reg           <= y_next;
        base_reg        <= base_next;
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        nb_base_reg     <= nb_base_next;
        cp_cnt_reg      <= cp_cnt_next;
        cpw_addr_reg    <= cp_cnt_reg;
        pend_run_reg    <= pend_run_next;
        pend_inside_reg <= pend_inside_next;
        out_value_reg   <= out_value_next;
        out_done_reg    <= out_done_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        base_next        = base_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        nb_base_next     = nb_base_reg;
        cp_cnt_next      = cp_cnt_reg;
        pend_run_next    = pend_run_reg;
        pend_inside_next = pend_inside_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_value_next   = out_value_reg;
        out_done_next    = out_done_reg;
        g_we             = 1'b0;
        g_waddr          = cmd_addr;
        g_wdata          = cmd.occupancy;
        g_re             = 1'b0;
        g_raddr          = cmd_addr;
        s_re             = 1'b0;
        advance          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.kind)
                        KIND_WRITE:
                        begin
                            g_we = cmd_inside;
                        end
                        KIND_READ:
                        begin
                            g_re             = cmd_inside;
                            pend_run_next    = 1'b0;
                            pend_inside_next = cmd_inside;
                            state_next       = ST_DELIVER;
                        end
                        KIND_RUN:
                        begin
                            cp_cnt_next = '0;
                            state_next  = ST_COPY;
                        end
                        default: ;
                    endcase
                end
            end

            ST_DELIVER:
            begin
                // grid read data stays put until the next read is issued
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = (pend_run_reg || !pend_inside_reg) ? '0 : g_rdata;
                    out_done_next  = pend_run_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_COPY:
            begin
                g_re        = 1'b1;
                g_raddr     = cp_cnt_reg;
                cp_cnt_next = cp_cnt_reg + CELL_AW'(1);
                if (cp_cnt_reg == CELL_AW'(CELL_COUNT - 1))
                begin
                    x_next        = '0;
                    y_next        = '0;
                    base_next     = '0;
                    pend_run_next = 1'b1;
                    state_next    = area_empty ? ST_DELIVER : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                s_re       = 1'b1;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (s_rdata > thr_reg)
                begin
                    dx_next      = r_neg;
                    dy_next      = r_neg;
                    nb_base_next = $signed({1'b0, (NB_W-1)'(base_reg)}) - $signed({1'b0, r_rows});
                    state_next   = ST_DISC;
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            ST_DISC:
            begin
                g_we    = pt_ok;
                g_waddr = nb_addr[CELL_AW-1:0];
                g_wdata = OCC_FULL;
                if (dx_reg == r_pos)
                begin
                    dx_next      = r_neg;
                    dy_next      = dy_reg + (R_W+1)'(1);
                    nb_base_next = nb_base_reg + NB_W'(GRID_WIDTH);
                    if (dy_reg == r_pos)
                    begin
                        advance = 1'b1;
                    end
                end
                else
                begin
                    dx_next = dx_reg + (R_W+1)'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next cell of the scan, or finish the run
        if (advance)
        begin
            if (last_x)
            begin
                x_next = '0;
                if (last_y)
                begin
                    state_next = ST_DELIVER;
                end
                else
                begin
                    y_next     = y_reg + YW'(1);
                    base_next  = base_reg + CELL_AW'(GRID_WIDTH);
                    state_next = ST_SCAN;
                end
            end
            else
            begin
                x_next     = x_reg + XW'(1);
                state_next = ST_SCAN;
            end
        end
    end

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_value = out_value_reg;
    assign rsp.run_done   = out_done_reg;

endmodule

>>> design/oggd_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module oggd_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/oggd_disc_unit.sv
// Disc membership test: dx*dx + dy*dy <= r*r on small offsets.
module oggd_disc_unit #(
    parameter int R_W = 4
) (
    input  logic signed [R_W:0]   dx,
    input  logic signed [R_W:0]   dy,
    input  logic        [R_W-1:0] r,
    output logic                  in_disc
);

    logic [R_W-1:0]   adx;
    logic [R_W-1:0]   ady;
    logic [2*R_W-1:0] dx_sq;
    logic [2*R_W-1:0] dy_sq;
    logic [2*R_W-1:0] r_sq;
    logic [2*R_W:0]   dist_sq;

    // offsets never exceed r in magnitude, so |d| fits in R_W bits
    assign adx = dx[R_W] ? R_W'(-dx) : dx[R_W-1:0];
    assign ady = dy[R_W] ? R_W'(-dy) : dy[R_W-1:0];

    assign dx_sq   = (2*R_W)'(adx) * (2*R_W)'(adx);
    assign dy_sq   = (2*R_W)'(ady) * (2*R_W)'(ady);
    assign r_sq    = (2*R_W)'(r) * (2*R_W)'(r);
    assign dist_sq = (2*R_W+1)'(dx_sq) + (2*R_W+1)'(dy_sq);
    assign in_disc = (dist_sq <= (2*R_W+1)'(r_sq));

endmodule

>>> design/oggd_checker.sv
// Port-level assertions for the dilation block, bound to its top level.
module oggd_checker import oggd_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic [KIND_W-1:0] cmd_kind,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [OCC_W-1:0]  rsp_value,
    input logic              rsp_done
);

    // Writes and unused kinds finish in the cycle they are taken
    a_write_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_kind != KIND_READ && cmd_kind != KIND_RUN
        |=> cmd_ready)
        else $error("command port stalled after a word that gives no response");

    // Reads and runs hold off the command port while in progress
    a_busy_after_result_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_kind == KIND_READ || cmd_kind == KIND_RUN)
        |=> !cmd_ready)
        else $error("command port ready right after a read or run word");

    a_done_carries_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_done |-> rsp_value == '0)
        else $error("run completion word with nonzero cell value");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_done))
        else $error("stalled response word changed or dropped");

endmodule

bind occupancy_grid_disc_dilation oggd_checker u_oggd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_kind  (cmd.kind),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_value (rsp.cell_value),
    .rsp_done  (rsp.run_done)
);

>>> tb/oggd_inflation_checker.sv
// Checker for the grid inflation block: predicts every response word and compares it.
module oggd_inflation_checker import oggd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    oggd_cmd_if                   cmd,
    oggd_rsp_if                   rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GW   = DEF_GRID_WIDTH;
    localparam int GH   = DEF_GRID_HEIGHT;
    localparam int MAXR = DEF_MAX_RADIUS;

    typedef struct packed {
        logic [OCC_W-1:0] cell_value;
        logic             run_done;
    } reply_t;

    logic [OCC_W-1:0]    grid_copy [GW*GH];
    logic [OCC_W-1:0]    snap_copy [GW*GH];
    logic [RADIUS_W-1:0] radius;
    logic [THR_W-1:0]    threshold;
    logic [DIM_W-1:0]    width_cfg;
    logic [DIM_W-1:0]    height_cfg;
    reply_t              replies_due [$];

    function automatic int area_w();
        return (width_cfg > GW) ? GW : int'(width_cfg);
    endfunction

    function automatic int area_h();
        return (height_cfg > GH) ? GH : int'(height_cfg);
    endfunction

    // Snapshot, then stamp a full disc around every obstacle of the snapshot.
    function automatic void inflate_grid();
        int w;
        int h;
        int r;
        int nx;
        int ny;
        w = area_w();
        h = area_h();
        r = (radius > MAXR) ? MAXR : int'(radius);
        snap_copy = grid_copy;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                if (snap_copy[y*GW + x] > threshold)
                begin
                    for (int dy = -r; dy <= r; dy++)
                    begin
                        for (int dx = -r; dx <= r; dx++)
                        begin
                            nx = x + dx;
                            ny = y + dy;
                            if (dx*dx + dy*dy <= r*r && nx >= 0 && nx < w && ny >= 0
                                && ny < h)
                                grid_copy[ny*GW + nx] = OCC_FULL;
                        end
                    end
                end
            end
        end
    endfunction

    function automatic void take_command();
        int     x;
        int     y;
        logic   in_area;
        reply_t due;
        x = int'(cmd.cell_x);
        y = int'(cmd.cell_y);
        in_area = (x < area_w()) && (y < area_h());
        case (cmd.kind)
            KIND_WRITE:
            begin
                if (in_area)
                    grid_copy[y*GW + x] = cmd.occupancy;
            end
            KIND_RUN:
            begin
                inflate_grid();
                due.cell_value = '0;
                due.run_done   = 1'b1;
                replies_due.insert(replies_due.size(), due);
            end
            KIND_READ:
            begin
                due.cell_value = in_area ? grid_copy[y*GW + x] : '0;
                due.run_done   = 1'b0;
                replies_due.insert(replies_due.size(), due);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_response();
        reply_t due;
        if (replies_due.size() == 0)
        begin
            $display("%0t: unexpected response word: cell_value=%0d run_done=%0b",
                     $time, rsp.cell_value, rsp.run_done);
            fail_count++;
        end
        else
        begin
            due = replies_due[0];
            replies_due.delete(0);
            if (rsp.cell_value !== due.cell_value)
            begin
                $display("%0t: cell_value mismatch: expected %0d, got %0d",
                         $time, due.cell_value, rsp.cell_value);
                fail_count++;
            end
            if (rsp.run_done !== due.run_done)
            begin
                $display("%0t: run_done mismatch: expected %0b, got %0b",
                         $time, due.run_done, rsp.run_done);
                fail_count++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius     = RADIUS_RST;
            threshold  = THRESHOLD_RST;
            width_cfg  = WIDTH_RST;
            height_cfg = HEIGHT_RST;
            replies_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // responses first: a word leaving now never belongs to a command taken now
            if (rsp.valid && rsp.ready)
                check_response();
            if (cmd.valid && cmd.ready)
                take_command();
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RADIUS:    radius     = cfg_data[RADIUS_W-1:0];
                    CFG_THRESHOLD: threshold  = cfg_data[THR_W-1:0];
                    CFG_WIDTH:     width_cfg  = cfg_data[DIM_W-1:0];
                    CFG_HEIGHT:    height_cfg = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            pending = replies_due.size();
        end
    end

endmodule

>>> tb/occupancy_grid_disc_dilation_tb.sv
// Testbench top for the grid inflation block: clock, reset, stimulus and verdict.
module occupancy_grid_disc_dilation_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import oggd_pkg::*;

    localparam int GW           = DEF_GRID_WIDTH;
    localparam int GH           = DEF_GRID_HEIGHT;
    localparam int RANDOM_WORDS = 1400;
    // drain after the last response word so a trailing write has landed
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;
    // watchdog limit on the whole simulation, counted in clock cycles
    localparam int CYCLE_LIMIT  = 20_000_000;
    // bound on cells in use times disc square per run, keeps runs short
    localparam int DISC_BUDGET  = 15000;

    // kind 3 has no meaning to the block: it must swallow the word silently
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    oggd_cmd_if cmd_ch ();
    oggd_rsp_if rsp_ch ();

    occupancy_grid_disc_dilation u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    oggd_inflation_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Stimulus-side view of the block: which cells hold a defined value and
    // what area is in use. Reads and runs must never touch an unwritten cell
    // inside the area, so everything below steers around those.
    bit                  cell_written [GW*GH];
    int                  written_cells [$];
    logic [RADIUS_W-1:0] radius_now;
    logic [THR_W-1:0]    thr_now;
    logic [DIM_W-1:0]    width_now;
    logic [DIM_W-1:0]    height_now;

    bit offering;      // cmd valid currently held high
    int burst_left;    // words left in the current sender burst
    int words_sent;    // accepted words, ignored ones excluded
    int hold_req;      // bumped by stimulus to ask for one long receiver hold
    int hold_seen;
    int watch_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Simulation watchdog: a correct simulation never gets close to this.
    initial
    begin
        for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++)
            @(posedge clk);
        $display("%0t: timeout, %0d response words still due", $time, pending);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int eff_w();
        return (width_now > GW) ? GW : int'(width_now);
    endfunction

    function automatic int eff_h();
        return (height_now > GH) ? GH : int'(height_now);
    endfunction

    function automatic bit area_empty();
        return (eff_w() == 0) || (eff_h() == 0);
    endfunction

    // Mix of short bursts, medium ones and long stretches with no idling.
    function automatic int burst_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(0, 3);
        else if (sel < 8)
            return $urandom_range(4, 30);
        else
            return 120;
    endfunction

    // Occupancy values cluster on the threshold edge and the two extremes.
    function automatic logic [OCC_W-1:0] pick_occupancy();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return OCC_FULL;
            2: return thr_now;
            3: return (thr_now == OCC_FULL) ? thr_now : thr_now + 1'b1;
            default: return OCC_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one command word (entered at a falling edge) and wait until it
    // is taken. Returns at a falling edge, with valid either still high for
    // the next word of the burst or lowered for a gap that has elapsed.
    task automatic put_word(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [OCC_W-1:0] occ);
        int idx;
        idx = int'(y)*GW + int'(x);
        cmd_ch.valid     <= 1'b1;
        cmd_ch.kind      <= kind;
        cmd_ch.cell_x    <= x;
        cmd_ch.cell_y    <= y;
        cmd_ch.occupancy <= occ;
        offering = 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (kind == KIND_WRITE && x < eff_w() && y < eff_h() && !cell_written[idx])
        begin
            cell_written[idx] = 1'b1;
            written_cells.insert(written_cells.size(), idx);
        end
        if (kind != KIND_UNUSED)
            words_sent++;
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            cmd_ch.valid <= 1'b0;
            offering = 1'b0;
            if ($urandom_range(0, 15) == 0)
                repeat (20) @(negedge clk);
            else
                repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = burst_length();
        end
    endtask

    // Sender pause: nothing offered until every response word is in, then a
    // drain of DRAIN_CYCLES so a trailing write has surely landed.
    task automatic quiesce();
        if (offering)
        begin
            cmd_ch.valid <= 1'b0;
            offering = 1'b0;
            @(negedge clk);
        end
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // All four registers, back to back, only while the block is idle.
    // Bits above each register's width carry junk that must be dropped.
    task automatic configure(input logic [RADIUS_W-1:0] r, input logic [THR_W-1:0] thr,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RADIUS;
        cfg_data  <= {junk[7:4], r};
        @(negedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= thr;
        @(negedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data  <= {junk[0], w};
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= {junk[1], h};
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        radius_now = r;
        thr_now    = thr;
        width_now  = w;
        height_now = h;
    endtask

    // Write every still-undefined cell of the area, then start a run.
    task automatic fill_and_run();
        for (int y = 0; y < eff_h(); y++)
            for (int x = 0; x < eff_w(); x++)
                if (!cell_written[y*GW + x])
                    put_word(KIND_WRITE, COORD_W'(x), COORD_W'(y), pick_occupancy());
        put_word(KIND_RUN, COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)),
                 OCC_W'($urandom_range(0, 255)));
    endtask

    // Read a cell that is either defined or outside the area in use.
    task automatic read_cell();
        int sel;
        int x;
        int y;
        int idx;
        sel = $urandom_range(0, 9);
        if (sel < 5 && !area_empty())
        begin
            x = $urandom_range(0, eff_w() - 1);
            y = $urandom_range(0, eff_h() - 1);
        end
        else if (sel < 8)
        begin
            idx = written_cells[$urandom_range(0, written_cells.size() - 1)];
            x = idx % GW;
            y = idx / GW;
        end
        else
        begin
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
        end
        if (x < eff_w() && y < eff_h() && !cell_written[y*GW + x])
        begin
            idx = written_cells[$urandom_range(0, written_cells.size() - 1)];
            x = idx % GW;
            y = idx / GW;
        end
        put_word(KIND_READ, COORD_W'(x), COORD_W'(y), OCC_W'($urandom_range(0, 255)));
    endtask

    task automatic random_word();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3)
        begin
            fill_and_run();
        end
        else if (sel < 7)
        begin
            put_word(KIND_UNUSED, COORD_W'($urandom_range(0, 63)),
                     COORD_W'($urandom_range(0, 63)), OCC_W'($urandom_range(0, 255)));
        end
        else if (sel < 50)
        begin
            // mostly inside the area; some anywhere, dropped by the block when outside the area
            if (area_empty() || $urandom_range(0, 9) == 0)
                put_word(KIND_WRITE, COORD_W'($urandom_range(0, 63)),
                         COORD_W'($urandom_range(0, 63)), pick_occupancy());
            else
                put_word(KIND_WRITE, COORD_W'($urandom_range(0, eff_w() - 1)),
                         COORD_W'($urandom_range(0, eff_h() - 1)), pick_occupancy());
        end
        else
        begin
            read_cell();
        end
    endtask

    // Pick a setting whose worst run stays cheap: the disc square times the
    // cells in use is kept under a budget, so a wide area means a small disc.
    task automatic pick_setting();
        logic [RADIUS_W-1:0] r;
        logic [THR_W-1:0]    thr;
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        int                  sel;
        int                  max_cells;
        int                  w_eff;
        int                  h_cap;
        sel = $urandom_range(0, 9);
        r = (sel < 2) ? '0 : (sel < 4) ? 4'd15 : RADIUS_W'($urandom_range(0, 15));
        sel = $urandom_range(0, 19);
        thr = (sel < 3) ? '0 : (sel < 6) ? 8'd255 : THR_W'($urandom_range(0, 255));
        max_cells = DISC_BUDGET / ((2*r + 1) * (2*r + 1));
        if (max_cells > 256) max_cells = 256;
        if (max_cells < 1)   max_cells = 1;
        sel = $urandom_range(0, 49);
        if (sel < 3)       w = '0;
        else if (sel < 8)  w = 7'd1;
        else if (sel < 13) w = 7'd64;
        else if (sel < 17) w = DIM_W'($urandom_range(65, 127));
        else               w = DIM_W'($urandom_range(1, 12));
        w_eff = (w > GW) ? GW : int'(w);
        if (w_eff > max_cells)
        begin
            w = DIM_W'(max_cells);
            w_eff = max_cells;
        end
        h_cap = max_cells / ((w_eff == 0) ? 1 : w_eff);
        if (h_cap > GH) h_cap = GH;
        sel = $urandom_range(0, 49);
        if (sel < 3)
            h = '0;
        else if (h_cap == GH && sel < 15)
            h = DIM_W'($urandom_range(64, 127));
        else
            h = DIM_W'($urandom_range(1, h_cap));
        configure(r, thr, w, h);
    endtask

    // Response side: own stall pattern, picked anew after each random stretch,
    // plus one long hold whenever the stimulus asks for one.
    initial
    begin
        int mode;
        int mode_left;
        rsp_ch.ready = 1'b0;
        hold_seen = 0;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
                    default: rsp_ch.ready <= ((mode_left % 16) >= 5);
                endcase
            end
        end
    end

    initial
    begin
        int target;
        int setting_count;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_RADIUS;
        cfg_data         = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.kind      = KIND_WRITE;
        cmd_ch.cell_x    = '0;
        cmd_ch.cell_y    = '0;
        cmd_ch.occupancy = '0;
        offering         = 1'b0;
        burst_left       = 0;
        words_sent       = 0;
        hold_req         = 0;
        radius_now       = RADIUS_RST;
        thr_now          = THRESHOLD_RST;
        width_now        = WIDTH_RST;
        height_now       = HEIGHT_RST;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting, full grid: corner cells, reads back, kind 3 must not
        // disturb the corner it names.
        put_word(KIND_WRITE, 6'd0, 6'd0, 8'h00);
        put_word(KIND_WRITE, 6'd63, 6'd63, 8'hFF);
        put_word(KIND_WRITE, 6'd63, 6'd0, 8'hA5);
        put_word(KIND_WRITE, 6'd0, 6'd63, 8'h5A);
        put_word(KIND_READ, 6'd0, 6'd0, 8'hFF);
        put_word(KIND_READ, 6'd63, 6'd63, 8'h00);
        put_word(KIND_READ, 6'd63, 6'd0, 8'h00);
        put_word(KIND_READ, 6'd0, 6'd63, 8'h00);
        put_word(KIND_UNUSED, 6'd63, 6'd63, 8'h00);
        put_word(KIND_READ, 6'd63, 6'd63, 8'h00);

        // Radius zero on a 3x2 area: only the obstacles themselves go full,
        // a value equal to the threshold is no obstacle. Outside the area a
        // write is dropped and a read gives zero.
        quiesce();
        configure(4'd0, 8'd124, 7'd3, 7'd2);
        put_word(KIND_WRITE, 6'd1, 6'd0, 8'd125);
        put_word(KIND_WRITE, 6'd2, 6'd0, 8'd124);
        put_word(KIND_WRITE, 6'd0, 6'd1, 8'd255);
        put_word(KIND_WRITE, 6'd1, 6'd1, 8'd0);
        put_word(KIND_WRITE, 6'd2, 6'd1, 8'd1);
        put_word(KIND_RUN, 6'd0, 6'd0, 8'd0);
        put_word(KIND_READ, 6'd1, 6'd0, 8'd0);
        put_word(KIND_READ, 6'd2, 6'd0, 8'd0);
        put_word(KIND_WRITE, 6'd5, 6'd5, 8'd77);
        put_word(KIND_READ, 6'd5, 6'd5, 8'd0);
        put_word(KIND_READ, 6'd63, 6'd63, 8'd0);

        // Width zero with a height above the grid: empty area, the run still
        // ends with a done word and every read is zero.
        quiesce();
        configure(4'd15, 8'd0, 7'd0, 7'd127);
        put_word(KIND_RUN, 6'd63, 6'd63, 8'hFF);
        put_word(KIND_READ, 6'd0, 6'd0, 8'd0);

        // Random part: one setting per stretch of words, each stretch opened
        // by a full sender pause.
        target = words_sent + RANDOM_WORDS;
        setting_count = 0;
        while (words_sent < target)
        begin
            quiesce();
            pick_setting();
            setting_count++;
            if (setting_count % 6 == 2)
            begin
                // receiver goes quiet while reads keep coming: block backs up
                hold_req++;
                repeat (30) read_cell();
            end
            repeat ($urandom_range(30, 60)) random_word();
            if ($urandom_range(0, 1) == 1)
                fill_and_run();
        end

        quiesce();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
